// ===== sv/adx_directional_index_assert.svh =====
// ----------------------------------------------------------------------------
// ADX assertion macros
// Shared assertion forms for the directional index checker.
// ----------------------------------------------------------------------------
`ifndef ADX_DIRECTIONAL_INDEX_ASSERT_SVH
`define ADX_DIRECTIONAL_INDEX_ASSERT_SVH

// property must hold at every edge outside reset
`define ADX_ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define ADX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/adx_pkg.sv =====
// ----------------------------------------------------------------------------
// ADX package
// Widths, constants and shared types of the directional index block.
// ----------------------------------------------------------------------------
package adx_pkg;

  localparam int PRICE_W    = 32;  // Q16.16 price
  localparam int DIFF_W     = 33;  // price difference, one guard bit
  localparam int SUM_W      = 48;  // smoothed sums
  localparam int ACC_W      = 32;  // DX sum / ADX
  localparam int CNT_W      = 8;   // bar and DX counters
  localparam int PER_W      = 7;   // period register
  localparam int PCT_W      = 23;  // Q7.16 result
  localparam int PCT_HEAD_W = 7;   // integer bits of a percentage quotient
  localparam int PROD_W     = SUM_W + PER_W;   // num * 100
  localparam int ADX_PROD_W = ACC_W + PER_W;   // adx * (p - 1)
  localparam int DX_W       = PCT_W + 1;       // DI+ + DI-
  localparam int DIV_W      = 48;  // divider dividend / remainder / divisor
  localparam int DIV_CNT_W  = 6;   // divider step counter

  localparam int IN_DATA_W  = 3 * PRICE_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_PAD_W  = 3;
  localparam int OUT_DATA_W = 3 * PCT_W + OUT_PAD_W;

  localparam logic [PER_W-1:0]     PERIOD_DEFAULT = 7'd14;
  localparam logic [PCT_W-1:0]     Q_FULL         = 23'd6553600;  // 100.0 in Q7.16
  localparam logic [PER_W-1:0]     PCT_SCALE      = 7'd100;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FULL = 6'd48;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_PCT  = 6'd23;

  // divider launch group
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctl_t;

endpackage

// ===== sv/adx_div.sv =====
// ----------------------------------------------------------------------------
// ADX serial divider
// Restoring divider, one quotient bit per cycle. Dividend bits shift in
// MSB first on top of a preloaded partial remainder, which must be below
// the divisor.
// ----------------------------------------------------------------------------
module adx_div import adx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [DIV_W-1:0] dividend,  // left-aligned bit stream
  input  logic [DIV_W-1:0] rem_init,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quot,
  output logic             done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     sr;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       rem_shift;
  logic [DIV_W+1:0]     trial;
  logic                 borrow;

  assign rem_shift = {rem, sr[DIV_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, dvs};
  assign borrow    = trial[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
        sr   <= dividend;
        rem  <= rem_init;
        dvs  <= divisor;
        quot <= '0;
      end else if (busy) begin
        rem  <= borrow ? rem_shift[DIV_W-1:0] : trial[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], ~borrow};
        sr   <= {sr[DIV_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/adx_directional_index.sv =====
// Once smoothing runs, a bar goes through three divisions by the period, up to
//   three percentage divisions and one ADX division; zero or full range
//   percentages skip their division. Output stalls add to the time per bar.
// Throughput: one bar at a time; all divisions share one divider.
// rst (sync, high) clears all series state and sets the period to 14.
// ----------------------------------------------------------------------------
// ADX directional index
// Wilder ADX with DI+ and DI-, one price bar per request, Q16.16 in and
// Q7.16 out. All divisions go through one serial divider.
// ----------------------------------------------------------------------------
module adx_directional_index import adx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: smoothing period, 0 means 14
  input  logic                  cfg_wr_en,
  input  logic [PER_W-1:0]      cfg_wr_data,
  // bar requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // high_price, low_price, close_price
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // row_valid, series_start
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // adx_value, DI+, DI-, pad
  output logic [0:0]            m_axis_tuser    // result_valid
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'h0001,
    ST_DIFF   = 14'h0002,  // raw differences vs previous bar
    ST_MOVE   = 14'h0004,  // true range and directional moves
    ST_ACC    = 14'h0008,  // summing phase add, or start smoothing
    ST_SDIV   = 14'h0010,
    ST_SWAIT  = 14'h0020,
    ST_PCHK   = 14'h0040,  // percentage: trivial cases, num * 100
    ST_PGO    = 14'h0080,
    ST_PWAIT  = 14'h0100,
    ST_DXPREP = 14'h0200,
    ST_ADX    = 14'h0400,
    ST_AGO    = 14'h0800,
    ST_AWAIT  = 14'h1000,
    ST_OUT    = 14'h2000
  } state_t;

  typedef enum logic [1:0] {
    LANE_TR,
    LANE_PDM,
    LANE_MDM
  } lane_t;

  typedef enum logic [1:0] {
    PCT_PLUS,
    PCT_MINUS,
    PCT_DX
  } pct_sel_t;

  state_t   state;
  lane_t    lane;
  pct_sel_t pct_sel;

  logic [PER_W-1:0] period_len;
  logic [PER_W-1:0] p;

  // latched request
  logic signed [PRICE_W-1:0] in_high, in_low, in_close;
  logic                      in_row_valid;

  // series state
  logic signed [PRICE_W-1:0] prev_high, prev_low, prev_close;
  logic [CNT_W-1:0]          bar_count;
  logic [SUM_W-1:0]          s_tr, s_pdm, s_mdm;
  logic [CNT_W-1:0]          dx_count;
  logic [ACC_W-1:0]          adx_accum;

  // per-bar flags
  logic sum_ph, push;

  // differences and moves
  logic signed [DIFF_W-1:0] hl, up, dn;
  logic [DIFF_W-1:0]        hpc_abs, lpc_abs;
  logic [DIFF_W-1:0]        tr, pdm, mdm;

  // percentage and ADX work registers
  logic [PCT_W-1:0]      pdi, mdi, dx;
  logic [DX_W-1:0]       dx_num, dx_den;
  logic [PROD_W-1:0]     pct_t;
  logic [ADX_PROD_W-1:0] adx_prod;
  logic                  adx_blend;

  // combinational helpers
  logic signed [DIFF_W-1:0] hx, lx, cpx, hpx, lpx;
  logic [DIFF_W-1:0]        tr_m1, tr_max;
  logic [CNT_W-1:0]         idx;
  logic [SUM_W-1:0]         pct_num, pct_den;
  logic                     pct_zero, pct_sat, pct_fin;
  logic [PCT_W-1:0]         pct_val;
  state_t                   pct_after;
  logic [SUM_W-1:0]         lane_sum;
  logic [DIFF_W-1:0]        lane_new;
  logic [SUM_W-1:0]         lane_upd;
  logic                     res_valid;
  logic [PCT_W-1:0]         adx_out;
  logic                     out_load;

  // divider
  div_ctl_t         div_ctl;
  logic [DIV_W-1:0] div_dividend, div_rem, div_divisor, div_quot;
  logic             div_done;

  assign p = (period_len == '0) ? PERIOD_DEFAULT : period_len;

  assign s_axis_tready = (state == ST_IDLE);

  // bar differences, sign-extended to 33 bits
  assign hx  = DIFF_W'(in_high);
  assign lx  = DIFF_W'(in_low);
  assign cpx = DIFF_W'(prev_close);
  assign hpx = DIFF_W'(prev_high);
  assign lpx = DIFF_W'(prev_low);
  assign idx = bar_count - 1'b1;

  // true range = max(h - l, |h - pc|, |l - pc|); h - l may be negative
  assign tr_m1  = (hl[DIFF_W-1] || (hpc_abs > hl)) ? hpc_abs : hl;
  assign tr_max = (lpc_abs > tr_m1) ? lpc_abs : tr_m1;

  // percentage operand select
  always_comb begin
    case (pct_sel)
      PCT_PLUS: begin
        pct_num = s_pdm;
        pct_den = s_tr;
      end
      PCT_MINUS: begin
        pct_num = s_mdm;
        pct_den = s_tr;
      end
      PCT_DX: begin
        pct_num = SUM_W'(dx_num);
        pct_den = SUM_W'(dx_den);
      end
      default: begin
        pct_num = s_pdm;
        pct_den = s_tr;
      end
    endcase
  end

  assign pct_zero = (pct_den == '0);
  assign pct_sat  = (pct_num >= pct_den);
  assign pct_fin  = ((state == ST_PCHK) && (pct_zero || pct_sat)) ||
                    ((state == ST_PWAIT) && div_done);
  assign pct_val  = (state == ST_PWAIT) ? div_quot[PCT_W-1:0] :
                    (pct_zero ? '0 : Q_FULL);

  // where to go once a percentage is known
  always_comb begin
    case (pct_sel)
      PCT_PLUS:  pct_after = ST_PCHK;
      PCT_MINUS: pct_after = (push && (s_tr != '0)) ? ST_DXPREP : ST_OUT;
      PCT_DX:    pct_after = ST_ADX;
      default:   pct_after = ST_OUT;
    endcase
  end

  // smoothing lane select: sum - sum/p + new
  always_comb begin
    case (lane)
      LANE_TR: begin
        lane_sum = s_tr;
        lane_new = tr;
      end
      LANE_PDM: begin
        lane_sum = s_pdm;
        lane_new = pdm;
      end
      LANE_MDM: begin
        lane_sum = s_mdm;
        lane_new = mdm;
      end
      default: begin
        lane_sum = s_tr;
        lane_new = tr;
      end
    endcase
  end

  assign lane_upd = lane_sum - div_quot + SUM_W'(lane_new);

  // divider launch
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = DIV_STEPS_FULL;
    div_dividend  = lane_sum;
    div_rem       = '0;
    div_divisor   = DIV_W'(p);
    case (state)
      ST_SDIV: begin
        div_ctl.start = 1'b1;
      end
      ST_PGO: begin
        // quotient < 2^23, so pct_t >> 7 is already below the divisor
        div_ctl.start = 1'b1;
        div_ctl.steps = DIV_STEPS_PCT;
        div_rem       = pct_t[PROD_W-1:PCT_HEAD_W];
        div_dividend  = {pct_t[PCT_HEAD_W-1:0], {(DIV_W-PCT_HEAD_W){1'b0}}};
        div_divisor   = pct_den;
      end
      ST_AGO: begin
        div_ctl.start = 1'b1;
        div_dividend  = adx_blend ? DIV_W'(adx_prod + ADX_PROD_W'(dx)) :
                                    DIV_W'(adx_accum);
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  adx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .rem_init (div_rem),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  // result gating
  assign res_valid = (bar_count >= {p, 1'b1}) && (dx_count >= CNT_W'(p));
  assign adx_out   = (adx_accum > ACC_W'(Q_FULL)) ? Q_FULL : adx_accum[PCT_W-1:0];

  // output register loads once it is empty or being taken
  assign out_load  = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      period_len <= PERIOD_DEFAULT;
    end else if (cfg_wr_en) begin
      period_len <= cfg_wr_data;
    end
  end

  // sequencer and series state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_high  <= '0;
      prev_low   <= '0;
      prev_close <= '0;
      bar_count  <= '0;
      s_tr       <= '0;
      s_pdm      <= '0;
      s_mdm      <= '0;
      dx_count   <= '0;
      adx_accum  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_high      <= s_axis_tdata[PRICE_W-1:0];
            in_low       <= s_axis_tdata[2*PRICE_W-1:PRICE_W];
            in_close     <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
            in_row_valid <= s_axis_tuser[0];
            pct_sel      <= PCT_PLUS;
            // series start wipes state before the bar is taken
            if (s_axis_tuser[1]) begin
              prev_high  <= '0;
              prev_low   <= '0;
              prev_close <= '0;
              bar_count  <= '0;
              s_tr       <= '0;
              s_pdm      <= '0;
              s_mdm      <= '0;
              dx_count   <= '0;
              adx_accum  <= '0;
            end
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          hl      <= hx - lx;
          hpc_abs <= (hx >= cpx) ? (hx - cpx) : (cpx - hx);
          lpc_abs <= (lx >= cpx) ? (lx - cpx) : (cpx - lx);
          up      <= hx - hpx;
          dn      <= lpx - lx;
          sum_ph  <= idx < CNT_W'(p);
          push    <= in_row_valid && (bar_count != '0) && (bar_count >= CNT_W'(p));
          if (in_row_valid) begin
            prev_high  <= in_high;
            prev_low   <= in_low;
            prev_close <= in_close;
            if (bar_count != '1) begin
              bar_count <= bar_count + 1'b1;
            end
          end
          state <= (in_row_valid && (bar_count != '0)) ? ST_MOVE : ST_PCHK;
        end
        ST_MOVE: begin
          tr    <= tr_max;
          pdm   <= ((up > dn) && !up[DIFF_W-1] && (up != '0)) ? up : '0;
          mdm   <= ((dn > up) && !dn[DIFF_W-1] && (dn != '0)) ? dn : '0;
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (sum_ph) begin
            s_tr  <= s_tr + SUM_W'(tr);
            s_pdm <= s_pdm + SUM_W'(pdm);
            s_mdm <= s_mdm + SUM_W'(mdm);
            state <= ST_PCHK;
          end else begin
            lane  <= LANE_TR;
            state <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          state <= ST_SWAIT;
        end
        ST_SWAIT: begin
          if (div_done) begin
            case (lane)
              LANE_TR: begin
                s_tr  <= lane_upd;
                lane  <= LANE_PDM;
                state <= ST_SDIV;
              end
              LANE_PDM: begin
                s_pdm <= lane_upd;
                lane  <= LANE_MDM;
                state <= ST_SDIV;
              end
              default: begin
                s_mdm <= lane_upd;
                state <= ST_PCHK;
              end
            endcase
          end
        end
        ST_PCHK, ST_PWAIT: begin
          if (pct_fin) begin
            case (pct_sel)
              PCT_PLUS: begin
                pdi     <= pct_val;
                pct_sel <= PCT_MINUS;
              end
              PCT_MINUS: begin
                mdi <= pct_val;
              end
              default: begin
                dx <= pct_val;
              end
            endcase
            state <= pct_after;
          end else if (state == ST_PCHK) begin
            pct_t <= PROD_W'(pct_num) * PROD_W'(PCT_SCALE);
            state <= ST_PGO;
          end
        end
        ST_PGO: begin
          state <= ST_PWAIT;
        end
        ST_DXPREP: begin
          dx_num  <= (pdi >= mdi) ? DX_W'(pdi - mdi) : DX_W'(mdi - pdi);
          dx_den  <= DX_W'(pdi) + DX_W'(mdi);
          pct_sel <= PCT_DX;
          state   <= ST_PCHK;
        end
        ST_ADX: begin
          if (dx_count != '1) begin
            dx_count <= dx_count + 1'b1;
          end
          if (dx_count < CNT_W'(p)) begin
            // averaging phase: sum DX, divide once the period is full
            adx_accum <= adx_accum + ACC_W'(dx);
            adx_blend <= 1'b0;
            state     <= ((dx_count + 1'b1) == CNT_W'(p)) ? ST_AGO : ST_OUT;
          end else begin
            adx_prod  <= ADX_PROD_W'(adx_accum) * ADX_PROD_W'(p - 1'b1);
            adx_blend <= 1'b1;
            state     <= ST_AGO;
          end
        end
        ST_AGO: begin
          state <= ST_AWAIT;
        end
        ST_AWAIT: begin
          if (div_done) begin
            adx_accum <= div_quot[ACC_W-1:0];
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result valid: set on load, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (res_valid) begin
        m_axis_tdata <= {{OUT_PAD_W{1'b0}}, mdi, pdi, adx_out};
      end else begin
        m_axis_tdata <= '0;
      end
      m_axis_tuser <= res_valid;
    end
  end

endmodule

// ===== sv/adx_chk.sv =====
// ----------------------------------------------------------------------------
// ADX port checker
// Watches the directional index ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "adx_directional_index_assert.svh"

module adx_chk import adx_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser
);

  // one bar in flight: a taken request closes the input for a while
  `ADX_ASSERT_NEXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

  // not-valid results carry all-zero fields
  `ADX_ASSERT_HOLDS(a_invalid_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "invalid result not zero")

  // every percentage stays within 100.0
  `ADX_ASSERT_HOLDS(a_pct_range, clk, rst, !m_axis_tvalid || (m_axis_tdata[PCT_W-1:0] <= Q_FULL && m_axis_tdata[2*PCT_W-1:PCT_W] <= Q_FULL && m_axis_tdata[3*PCT_W-1:2*PCT_W] <= Q_FULL), "result above 100")

  // stalled result holds
  `ADX_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind adx_directional_index adx_chk u_adx_chk (.*);
